// ----- src/skf_pkg.sv -----
// Shared types and constants for the scalar Kalman pressure filter.
// No dependencies; imported by the controller, datapath and top level.
package skf_pkg;

    localparam int SAMPLE_W            = 28;
    localparam int VAR_W               = 32;
    localparam int TDATA_W             = 32;
    localparam int CFG_IDX_W           = 2;
    localparam int GAIN_FRAC_BITS_DEF  = 16;

    localparam logic [VAR_W-1:0] PROC_NOISE_RST = 32'd655;
    localparam logic [VAR_W-1:0] MEAS_NOISE_RST = 32'd655360;
    localparam logic [VAR_W-1:0] INIT_VAR_RST   = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 2'd2;

    typedef struct packed {
        logic load_in;
        logic pred;
        logic div_step;
        logic div_first;
        logic mul_gain;
        logic mul_var;
        logic commit;
    } t_dp_cmd;

endpackage

// ----- src/skf_ctrl.sv -----
// Sequencing controller for the scalar Kalman pressure filter.
// Depends on skf_pkg; drives the command struct of skf_datapath.
module skf_ctrl #(
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output skf_pkg::t_dp_cmd o_cmd
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(GAIN_FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_MULG,
        ST_MULV,
        ST_COMMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_in_ready;
    logic             r_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = r_in_ready && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = accept;
        o_cmd.pred      = (r_state == ST_PRED);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.div_first = (r_cnt == CNT_TOP);
        o_cmd.mul_gain  = (r_state == ST_MULG);
        o_cmd.mul_var   = (r_state == ST_MULV);
        o_cmd.commit    = (r_state == ST_COMMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == ST_COMMIT) && out_free)
                           || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    r_in_ready <= !accept;
                    if (accept) begin
                        r_state <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    r_cnt   <= CNT_TOP;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_MULG;
                    end
                end
                ST_MULG: begin
                    r_state <= ST_MULV;
                end
                ST_MULV: begin
                    r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_in_ready  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ----- src/skf_datapath.sv -----
// Datapath of the scalar Kalman pressure filter: config registers, state,
// restoring gain divider, shared multiplier and output register. Uses skf_pkg.
module skf_datapath #(
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  skf_pkg::t_dp_cmd                i_cmd,
    input  logic                            i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [skf_pkg::VAR_W-1:0]       i_cfg_data,
    input  logic [skf_pkg::SAMPLE_W-1:0]    i_sample,
    output logic [skf_pkg::SAMPLE_W-1:0]    o_filtered
);
    import skf_pkg::*;

    localparam int G      = GAIN_FRAC_BITS;
    localparam int GAIN_W = G + 1;
    localparam int DEN_W  = VAR_W + 1;
    localparam int REM_W  = VAR_W + 2;
    localparam int PROD_W = GAIN_W + VAR_W;
    localparam int EST_W  = SAMPLE_W + 2;
    localparam logic [GAIN_W-1:0] ONE  = GAIN_W'(1) << G;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (G - 1);
    localparam logic [SAMPLE_W-1:0] EST_MAX = '1;

    logic [VAR_W-1:0]    r_proc_noise, r_meas_noise;
    logic [SAMPLE_W-1:0] r_est;
    logic [VAR_W-1:0]    r_var;
    logic [SAMPLE_W-1:0] r_sample;
    logic [VAR_W-1:0]    r_pv;
    logic [DEN_W-1:0]    r_den;
    logic [REM_W-1:0]    r_rem;
    logic [GAIN_W-1:0]   r_quo;
    logic [GAIN_W-1:0]   r_gain;
    logic [SAMPLE_W-1:0] r_mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_out;

    logic [VAR_W:0]      pv_sum;
    logic [VAR_W-1:0]    pv_sat;
    logic [REM_W-1:0]    trial;
    logic                ge;
    logic [GAIN_W-1:0]   gain_eff;
    logic [GAIN_W-1:0]   mul_a;
    logic [VAR_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]   rnd;
    logic [SAMPLE_W:0]   step;
    logic [EST_W-1:0]    est_next;
    logic [SAMPLE_W-1:0] est_clamp;
    logic [DEN_W-1:0]    var_shift;
    logic [VAR_W-1:0]    var_sat;

    assign pv_sum = {1'b0, r_var} + {1'b0, r_proc_noise};
    assign pv_sat = pv_sum[VAR_W] ? '1 : pv_sum[VAR_W-1:0];

    assign trial = i_cmd.div_first ? r_rem : {r_rem[REM_W-2:0], 1'b0};
    assign ge    = (trial >= {1'b0, r_den});

    assign gain_eff = (r_den == '0) ? '0 : r_quo;

    always_comb begin
        if (i_cmd.mul_gain) begin
            mul_a = gain_eff;
            mul_b = VAR_W'(r_mag);
        end else begin
            mul_a = ONE - r_gain;
            mul_b = r_pv;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign rnd  = r_prod + HALF;
    assign step = rnd[G +: SAMPLE_W + 1];
    assign est_next = r_neg ? ({2'b00, r_est} - {1'b0, step})
                            : ({2'b00, r_est} + {1'b0, step});
    always_comb begin
        if (est_next[EST_W-1]) begin
            est_clamp = '0;
        end else if (est_next[EST_W-2]) begin
            est_clamp = EST_MAX;
        end else begin
            est_clamp = est_next[SAMPLE_W-1:0];
        end
    end

    assign var_shift = rnd[G +: DEN_W];
    assign var_sat   = var_shift[VAR_W] ? '1 : var_shift[VAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_noise <= PROC_NOISE_RST;
            r_meas_noise <= MEAS_NOISE_RST;
            r_var        <= INIT_VAR_RST;
            r_est        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROC_NOISE: r_proc_noise <= i_cfg_data;
                    CFG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                    CFG_INIT_VAR: begin
                        r_var <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mul_var) begin
                r_est <= est_clamp;
            end
            if (i_cmd.commit) begin
                r_var <= var_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
        end
        if (i_cmd.pred) begin
            r_pv  <= pv_sat;
            r_den <= {1'b0, pv_sat} + {1'b0, r_meas_noise};
            r_rem <= {2'b00, pv_sat};
            r_quo <= '0;
            if (r_sample >= r_est) begin
                r_neg <= 1'b0;
                r_mag <= r_sample - r_est;
            end else begin
                r_neg <= 1'b1;
                r_mag <= r_est - r_sample;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[GAIN_W-2:0], ge};
        end
        if (i_cmd.mul_gain) begin
            r_gain <= gain_eff;
            r_prod <= mul_p;
        end
        if (i_cmd.mul_var) begin
            r_prod <= mul_p;
        end
        if (i_cmd.commit) begin
            r_out <= r_est;
        end
    end

    assign o_filtered = r_out;

endmodule

// ----- src/scalar_kalman_pressure_filter.sv -----
// Scalar Kalman pressure filter, top level.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
// Input stream s_axis: one raw pressure sample (unsigned Q20.8 Pa) per request.
// Output stream m_axis: one filtered estimate (unsigned Q20.8 Pa) per request.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 process noise, 1 measurement noise, 2 initial variance, Q16.16);
//   writing the initial variance also reloads the error variance.
//   Write only while the block is idle; index 3 is ignored.
// Processing: after accept the sample passes the restoring gain divider, which
//   resolves one quotient bit per cycle, followed by two passes of the shared
//   multiplier, before the result reaches m_axis_tvalid.
// Flow: one sample at a time; s_axis_tready stays low until the result is committed.
// The output register holds a result while the next sample is processed; if
// m_axis_tready stays low the block holds in its final step until the old
// result is taken, then loads the new one and reopens s_axis_tready.
// Reset: synchronous, active low; estimate clears to 0, registers take their
// reset values and the error variance loads the initial variance.
module scalar_kalman_pressure_filter #(
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [skf_pkg::TDATA_W-1:0]       s_axis_tdata,   // [27:0] raw_sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [skf_pkg::TDATA_W-1:0]       m_axis_tdata,   // [27:0] filtered_value
    input  logic                              i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [skf_pkg::VAR_W-1:0]         i_cfg_data
);
    import skf_pkg::*;

    t_dp_cmd             cmd;
    logic [SAMPLE_W-1:0] filtered;

    skf_ctrl #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    skf_datapath #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata[SAMPLE_W-1:0]),
        .o_filtered (filtered)
    );

    assign m_axis_tdata = {{(TDATA_W - SAMPLE_W){1'b0}}, filtered};

endmodule

// ----- bench/scalar_kalman_pressure_filter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the scalar Kalman pressure filter: watches both streams and the
// register port, predicts each filtered estimate and compares it on arrival.
// Depends on skf_pkg.
module scalar_kalman_pressure_filter_checker #(
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [skf_pkg::TDATA_W-1:0]       i_in_data,   // [27:0] raw_sample
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [skf_pkg::TDATA_W-1:0]       i_out_data,  // [27:0] filtered_value
    input  logic                              i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [skf_pkg::VAR_W-1:0]         i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import skf_pkg::*;

    localparam logic [63:0] SAMPLE_MAX = 64'h0FFF_FFFF;
    localparam logic [63:0] VAR_MAX    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] estimate;
        logic [VAR_W-1:0]    variance;
    } t_filter_state;

    logic [VAR_W-1:0]    proc_noise;
    logic [VAR_W-1:0]    meas_noise;
    t_filter_state       filter;
    logic [SAMPLE_W-1:0] expected_estimates[$];

    function automatic t_filter_state predict_step(t_filter_state cur,
                                                   logic [SAMPLE_W-1:0] sample);
        logic [63:0]   one;
        logic [63:0]   half;
        logic [63:0]   pv;
        logic [63:0]   den;
        logic [63:0]   gain;
        logic [63:0]   est;
        logic [63:0]   smp;
        logic [63:0]   mag;
        logic [63:0]   scaled;
        logic [63:0]   next_est;
        logic          neg;
        t_filter_state nxt;
        one  = 64'd1 << GAIN_FRAC_BITS;
        half = one >> 1;
        pv   = {32'd0, cur.variance} + {32'd0, proc_noise};
        if (pv > VAR_MAX) pv = VAR_MAX;
        den  = pv + {32'd0, meas_noise};
        gain = (den == 64'd0) ? 64'd0 : (pv << GAIN_FRAC_BITS) / den;
        if (gain > one) gain = one;
        est = {36'd0, cur.estimate};
        smp = {36'd0, sample};
        neg = smp < est;
        mag = neg ? est - smp : smp - est;
        scaled = (gain * mag + half) >> GAIN_FRAC_BITS;
        if (neg) begin
            next_est = (scaled > est) ? 64'd0 : est - scaled;
        end else begin
            next_est = est + scaled;
            if (next_est > SAMPLE_MAX) next_est = SAMPLE_MAX;
        end
        scaled = ((one - gain) * pv + half) >> GAIN_FRAC_BITS;
        if (scaled > VAR_MAX) scaled = VAR_MAX;
        nxt.estimate = next_est[SAMPLE_W-1:0];
        nxt.variance = scaled[VAR_W-1:0];
        return nxt;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            proc_noise      = PROC_NOISE_RST;
            meas_noise      = MEAS_NOISE_RST;
            filter.estimate = '0;
            filter.variance = INIT_VAR_RST;
            expected_estimates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROC_NOISE: proc_noise = i_cfg_data;
                    CFG_MEAS_NOISE: meas_noise = i_cfg_data;
                    CFG_INIT_VAR: begin
                        filter.variance = i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_data[SAMPLE_W-1:0]);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_estimates.pop_front();
                    if (i_out_data[SAMPLE_W-1:0] !== want) begin
                        $display("%0t: filtered_value mismatch, expected %h, actual %h",
                                 $time, want, i_out_data[SAMPLE_W-1:0]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                filter = predict_step(filter, i_in_data[SAMPLE_W-1:0]);
                expected_estimates.push_back(filter.estimate);
            end
        end
        o_pending = expected_estimates.size();
    end

endmodule

// ----- bench/scalar_kalman_pressure_filter_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the scalar Kalman pressure filter: clock, reset, sample
// and register stimulus with random idling, and the final verdict.
// Depends on skf_pkg, the filter RTL and scalar_kalman_pressure_filter_checker.
module scalar_kalman_pressure_filter_test;
    import skf_pkg::*;

    localparam int                   CYCLE_LIMIT    = 500000;
    localparam int                   SETTLE_CYCLES  = 40;
    localparam int                   RANDOM_PHASES  = 8;
    localparam int                   PHASE_ITEMS    = 150;
    localparam int                   SAMPLE_MAX     = 268435455;
    localparam int                   SEA_LEVEL_Q8   = 25939200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;   // [27:0] raw_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;   // [27:0] filtered_value
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAR_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   send_left = 0;
    bit                   send_calm = 1'b0;

    scalar_kalman_pressure_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    scalar_kalman_pressure_filter_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scalar_kalman_pressure_filter_test: done, errors");
            $finish;
        end
    end

    function automatic logic [VAR_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        int gap;
        if (send_left == 0) begin
            send_left = $urandom_range(20, 120);
            send_calm = ($urandom_range(0, 3) == 0);
        end
        send_left = send_left - 1;
        gap = send_calm ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(sample);
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int  gap;
        int  left;
        bit  calm;
        m_axis_tready = 1'b0;
        left = 0;
        calm = 1'b0;
        forever begin
            if (left == 0) begin
                left = $urandom_range(20, 120);
                calm = ($urandom_range(0, 3) == 0);
            end
            left = left - 1;
            gap = calm ? 0 : $urandom_range(0, 16);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        int walk;
        int delta;
        logic [SAMPLE_W-1:0] sample;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_PROC_NOISE;
        i_cfg_data    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(28'h5555555);
        send_sample(28'hAAAAAAA);
        send_sample(28'h0000001);
        send_sample(SAMPLE_W'(SAMPLE_MAX - 1));

        // no measurement noise: estimate snaps to the sample
        drain();
        write_reg(CFG_MEAS_NOISE, '0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        send_sample(28'h1234567);

        // all variances zero: gain stays at zero
        drain();
        write_reg(CFG_PROC_NOISE, '0);
        write_reg(CFG_INIT_VAR, '0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);

        // saturate the predicted variance
        drain();
        write_reg(CFG_PROC_NOISE, '1);
        write_reg(CFG_MEAS_NOISE, '1);
        write_reg(CFG_INIT_VAR, '1);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));

        drain();
        write_reg(CFG_SPARE_IDX, $urandom);
        write_reg(CFG_MEAS_NOISE, 32'd1);
        send_sample(28'h0000100);
        send_sample(SAMPLE_W'(SEA_LEVEL_Q8));

        walk = SEA_LEVEL_Q8;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            write_reg(CFG_PROC_NOISE, random_word());
            write_reg(CFG_MEAS_NOISE, random_word());
            write_reg(CFG_INIT_VAR, random_word());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_IDX, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0: sample = SAMPLE_W'($urandom);
                    1: sample = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
                    default: begin
                        delta = $urandom_range(0, 8191);
                        walk  = walk + delta - 4096;
                        if (walk < 0) walk = 0;
                        if (walk > SAMPLE_MAX) walk = SAMPLE_MAX;
                        sample = SAMPLE_W'(walk);
                    end
                endcase
                send_sample(sample);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("scalar_kalman_pressure_filter_test: done, clean");
        end else begin
            $display("scalar_kalman_pressure_filter_test: done, errors");
        end
        $finish;
    end

endmodule
